// File: hw/rtl/sjpg_pkg.sv
package sjpg_pkg;

    // table and sine sizes
    localparam int TABLE_ENTRIES   = 17;
    localparam int SINE_TABLE_SIZE = 1024;
    localparam int JOINTS          = 22;

    // field widths
    localparam int ENTRY_IDX_W = 5;
    localparam int AMP_W       = 16;
    localparam int PHASE_W     = 15;
    localparam int JOINT_W     = 5;
    localparam int TICK_W      = 7;
    localparam int FREQ_W      = 19;
    localparam int RAMP_W      = 16;
    localparam int ENTRY_W     = AMP_W + PHASE_W + AMP_W;
    localparam int ENTRY_AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // angle arithmetic, 1/1024 degree
    localparam int FULL_CIRCLE = 368640;
    localparam int HALF_CIRCLE = 184320;
    localparam int ANG_W       = $clog2(FULL_CIRCLE);
    localparam int PHASE_SHIFT = 4;
    localparam int WRAP_LIMIT  = 114;

    // ramp position tick*pi/180 in 1/256 units
    localparam int RAMP_SCALE_Q16 = 292818;
    localparam int RAMP_SHIFT     = 16;
    localparam int FRAC_W         = RAMP_W;
    localparam int PREP_CYCLES    = FRAC_W;
    localparam int PREP_CNT_W     = $clog2(PREP_CYCLES);

    // sine quarter table
    localparam int S_BITS       = $clog2(SINE_TABLE_SIZE);
    localparam int SINE_AW      = S_BITS + 1;
    localparam int I_BITS       = S_BITS + 2;
    localparam int SINE_W       = 17;
    localparam int SINE_SHIFT   = 15;
    localparam int SINE_ROUND   = 1 << (SINE_SHIFT - 1);
    localparam int HALF_PI_Q30  = 1686629713;
    localparam int Q30_SHIFT    = 30;
    localparam int SERIES_TERMS = 10;

    // ceil(2^64/d) for the series divisors d = (2n)(2n+1), exact for terms below 2^33
    localparam logic [127:0] SERIES_ONE = 128'd1 << 64;
    localparam logic [127:0] SERIES_RECIP [1:SERIES_TERMS] = '{
        (SERIES_ONE + 128'd5) / 128'd6,
        (SERIES_ONE + 128'd19) / 128'd20,
        (SERIES_ONE + 128'd41) / 128'd42,
        (SERIES_ONE + 128'd71) / 128'd72,
        (SERIES_ONE + 128'd109) / 128'd110,
        (SERIES_ONE + 128'd155) / 128'd156,
        (SERIES_ONE + 128'd209) / 128'd210,
        (SERIES_ONE + 128'd271) / 128'd272,
        (SERIES_ONE + 128'd341) / 128'd342,
        (SERIES_ONE + 128'd419) / 128'd420
    };

    // table index floor(a*4S/FULL) by reciprocal, exact for a below FULL
    localparam int          IDX_SHIFT = 38;
    localparam logic [63:0] IDX_RECIP =
        ((64'd1 << IDX_SHIFT) * 64'(4 * SINE_TABLE_SIZE) + 64'(FULL_CIRCLE) - 64'd1)
        / 64'(FULL_CIRCLE);
    localparam int RECIP_W = $clog2(IDX_RECIP + 64'd1);
    localparam int IPROD_W = ANG_W + RECIP_W;

    // joints
    localparam logic [JOINT_W-1:0] JOINT_LAST = JOINT_W'(JOINTS - 1);
    localparam logic [JOINT_W-1:0] LEFT_FIRST = JOINT_W'(12);
    localparam logic [JOINT_W-1:0] NEG_OFF_LO = JOINT_W'(14);
    localparam logic [JOINT_W-1:0] NEG_OFF_HI = JOINT_W'(15);

    localparam logic [ENTRY_IDX_W-1:0] JOINT_SRC [0:JOINTS-1] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11,
        5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16
    };

    localparam logic signed [17:0] ANGLE_MAX = 18'sd32767;
    localparam logic signed [17:0] ANGLE_MIN = -18'sd32768;

    // commands and register indexes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;
    localparam logic CFG_STEP_FREQ = 1'b0;
    localparam logic CFG_RAMP_LEN  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_DRAIN
    } seq_state_t;

    typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_TABLE_SIZE];

    // Q15 quarter sine, Taylor series in Q30
    function automatic sine_tab_t build_sine_table();
        sine_tab_t    tab;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [127:0] wide;
        longint       sum;
        int           k;
        int           n;
        for (k = 0; k <= SINE_TABLE_SIZE; k++)
        begin
            x    = (64'(HALF_PI_Q30) * 64'(k)) >> S_BITS;
            x2   = (x * x) >> Q30_SHIFT;
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= SERIES_TERMS; n++)
            begin
                wide = 128'((term * x2) >> Q30_SHIFT) * SERIES_RECIP[n];
                term = wide[127:64];
                if (n[0])
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            tab[k] = SINE_W'((64'(sum) + 64'(SINE_ROUND)) >> SINE_SHIFT);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_Q = build_sine_table();

endpackage

// File: hw/rtl/sjpg_ram.sv
module sjpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/sinusoidal_joint_pattern_generator.sv
// channel  dir  handshake                  beat
// item     in   item_valid / item_stall    one load (cmd 0) or one tick (cmd 1)
// result   out  result_valid / result_stall one joint angle, 22 per tick, last on joint 21
// cfg      in   cfg_valid / cfg_ready      one register write (step_frequency, ramp_length)
//
// a load does not raise item_stall; after a tick is taken item_stall stays high through
// setup, where the ramp fraction divider makes one quotient bit per cycle, then
// 22 joint issues at one table read per cycle while result_stall is low, then the drain
// of the seven stages; the block goes back to idle once those stages are empty
// result_stall freezes the whole joint pipeline and the table read port
// reset clears the table valid bits, tick count, finished mark and registers

module sinusoidal_joint_pattern_generator
    import sjpg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          cmd,
    input  logic [ENTRY_IDX_W-1:0]        entry_index,
    input  logic signed [AMP_W-1:0]       amplitude,
    input  logic [PHASE_W-1:0]            phase,
    input  logic signed [AMP_W-1:0]       offset,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [JOINT_W-1:0]            joint_index,
    output logic signed [AMP_W-1:0]       angle,
    output logic                          finished,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [FREQ_W-1:0]             cfg_data
);

    seq_state_t state_reg, state_next;

    logic [FREQ_W-1:0]        step_freq_reg;
    logic [RAMP_W-1:0]        ramp_len_reg;
    logic [TICK_W-1:0]        tick_reg;
    logic                     finished_reg;
    logic                     fin_w_reg;
    logic [TABLE_ENTRIES-1:0] entry_valid_reg;
    logic [PREP_CNT_W-1:0]    prep_cnt_reg;
    logic [JOINT_W-1:0]       joint_cnt_reg;

    logic [ANG_W-1:0]   base_reg;
    logic [TICK_W-1:0]  tbits_reg;
    logic [RAMP_W-1:0]  div_rem_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [RAMP_W-1:0]  pos_reg;
    logic               ramp_on_reg;

    logic item_accept;
    logic adv;
    logic issue;
    logic pipe_busy;

    // ---------------- control
    always_comb
    begin
        state_next = state_reg;
        item_stall = 1'b1;
        issue      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid && cmd == CMD_TICK)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (prep_cnt_reg == PREP_CNT_W'(PREP_CYCLES - 1))
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                issue = adv;
                if (adv && joint_cnt_reg == JOINT_LAST)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;

    // tick bookkeeping
    logic                    wrap;
    logic [TICK_W-1:0]       tick_next;
    logic [TICK_W+FREQ_W-1:0] pos_prod;
    logic [RAMP_W-1:0]       pos_calc;

    assign wrap      = 32'(tick_reg) > WRAP_LIMIT;
    assign tick_next = (wrap ? '0 : tick_reg) + TICK_W'(1);
    assign pos_prod  = (TICK_W + FREQ_W)'(tick_reg) * (TICK_W + FREQ_W)'(RAMP_SCALE_Q16);
    assign pos_calc  = RAMP_W'(pos_prod >> RAMP_SHIFT);

    // setup: (step*tick) mod circle by bits of tick, ramp fraction by restoring division
    logic [ANG_W-1:0] sf_mod;
    logic [ANG_W:0]   h_dbl;
    logic [ANG_W:0]   h_red;
    logic [ANG_W:0]   h_add;
    logic [ANG_W-1:0] h_next;
    logic [RAMP_W:0]  d_sh;
    logic             d_ge;
    logic [RAMP_W-1:0] d_rem;

    always_comb
    begin
        sf_mod = (step_freq_reg >= ANG_W'(FULL_CIRCLE)) ?
                 step_freq_reg - ANG_W'(FULL_CIRCLE) : step_freq_reg;
        h_dbl  = {base_reg, 1'b0};
        h_red  = (h_dbl >= (ANG_W + 1)'(FULL_CIRCLE)) ? h_dbl - (ANG_W + 1)'(FULL_CIRCLE) : h_dbl;
        h_add  = h_red + (tbits_reg[TICK_W-1] ? (ANG_W + 1)'(sf_mod) : '0);
        h_next = ANG_W'((h_add >= (ANG_W + 1)'(FULL_CIRCLE)) ?
                        h_add - (ANG_W + 1)'(FULL_CIRCLE) : h_add);
        d_sh   = {div_rem_reg, 1'b0};
        d_ge   = d_sh >= (RAMP_W + 1)'(ramp_len_reg);
        d_rem  = RAMP_W'(d_ge ? d_sh - (RAMP_W + 1)'(ramp_len_reg) : d_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_freq_reg   <= '0;
            ramp_len_reg    <= '0;
            tick_reg        <= '0;
            finished_reg    <= 1'b0;
            entry_valid_reg <= '0;
            prep_cnt_reg    <= '0;
            joint_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STEP_FREQ: step_freq_reg <= cfg_data;
                    CFG_RAMP_LEN:  ramp_len_reg  <= cfg_data[RAMP_W-1:0];
                    default:       step_freq_reg <= step_freq_reg;
                endcase
            end
            if (item_accept && cmd == CMD_LOAD && 32'(entry_index) < TABLE_ENTRIES)
                entry_valid_reg[ENTRY_AW'(entry_index)] <= 1'b1;
            if (item_accept && cmd == CMD_TICK)
            begin
                tick_reg     <= tick_next;
                finished_reg <= finished_reg | wrap;
            end
            if (state_reg == ST_PREP)
                prep_cnt_reg <= prep_cnt_reg + PREP_CNT_W'(1);
            else
                prep_cnt_reg <= '0;
            if (state_reg != ST_RUN)
                joint_cnt_reg <= '0;
            else if (issue)
                joint_cnt_reg <= joint_cnt_reg + JOINT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && cmd == CMD_TICK)
        begin
            fin_w_reg   <= finished_reg | wrap;
            base_reg    <= '0;
            tbits_reg   <= tick_reg;
            pos_reg     <= pos_calc;
            div_rem_reg <= pos_calc;
            ramp_on_reg <= pos_calc < ramp_len_reg;
        end
        else if (state_reg == ST_PREP)
        begin
            if (32'(prep_cnt_reg) < TICK_W)
            begin
                base_reg  <= h_next;
                tbits_reg <= tbits_reg << 1;
            end
            div_rem_reg <= d_rem;
            frac_reg    <= {frac_reg[FRAC_W-2:0], d_ge};
        end
    end

    // ---------------- joint table
    logic [ENTRY_IDX_W-1:0] src;
    logic                   src_ok;
    logic [ENTRY_AW-1:0]    raddr;
    logic [ENTRY_W-1:0]     rdata;
    logic                   ram_we;

    assign src    = JOINT_SRC[joint_cnt_reg];
    assign src_ok = 32'(src) < TABLE_ENTRIES;
    assign raddr  = ENTRY_AW'(src);
    assign ram_we = item_accept && cmd == CMD_LOAD && 32'(entry_index) < TABLE_ENTRIES;

    sjpg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ENTRY_AW'(entry_index)),
        .wdata ({amplitude, phase, offset}),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    // ---------------- joint pipeline, every stage moves on adv
    assign adv = !result_valid || !result_stall;

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg;
    logic out_valid_reg;

    logic [JOINT_W-1:0] s1_j_reg, s2_j_reg, s3_j_reg, s4_j_reg, s5_j_reg, s6_j_reg, s7_j_reg;
    logic               s1_ok_reg;
    logic signed [AMP_W-1:0] s2_amp_reg, s3_amp_reg, s4_amp_reg;
    logic signed [AMP_W-1:0] s2_off_reg, s3_off_reg, s4_off_reg, s5_off_reg, s6_off_reg;
    logic signed [AMP_W-1:0] s7_off_reg;
    logic [ANG_W-1:0]   s2_ang_reg;
    logic [I_BITS-1:0]  s3_idx_reg;
    logic               s4_neg_reg;
    logic [SINE_W-1:0]  sine_reg;
    logic [AMP_W-1:0]   s5_mag_reg, s6_mag_reg, s7_mag_reg;
    logic               s5_sign_reg, s6_sign_reg, s7_sign_reg;
    logic [31:0]        s6_m1_reg, s6_p_reg, s7_p_reg;
    logic [AMP_W-1:0]   s7_qe_reg;
    logic [32:0]        s7_t_reg;

    logic [JOINT_W-1:0]      joint_index_reg;
    logic signed [AMP_W-1:0] angle_reg;
    logic                    finished_out_reg;
    logic                    last_reg;

    assign pipe_busy = s1_v_reg | s2_v_reg | s3_v_reg | s4_v_reg | s5_v_reg | s6_v_reg | s7_v_reg;

    // stage 1: entry fields and reduced sine argument
    logic signed [AMP_W-1:0] e_amp, e_off;
    logic [PHASE_W-1:0]      e_phase;
    logic [ANG_W+1:0]        arg_sum;
    logic [ANG_W-1:0]        arg_mod;

    always_comb
    begin
        e_amp   = s1_ok_reg ? rdata[ENTRY_W-1 -: AMP_W] : '0;
        e_phase = s1_ok_reg ? rdata[AMP_W +: PHASE_W] : '0;
        e_off   = s1_ok_reg ? rdata[AMP_W-1:0] : '0;
        arg_sum = ((ANG_W + 2)'(e_phase) << PHASE_SHIFT) + (ANG_W + 2)'(base_reg)
                + ((s1_j_reg >= LEFT_FIRST) ? (ANG_W + 2)'(HALF_CIRCLE) : '0);
        if (arg_sum >= (ANG_W + 2)'(2 * FULL_CIRCLE))
            arg_mod = ANG_W'(arg_sum - (ANG_W + 2)'(2 * FULL_CIRCLE));
        else if (arg_sum >= (ANG_W + 2)'(FULL_CIRCLE))
            arg_mod = ANG_W'(arg_sum - (ANG_W + 2)'(FULL_CIRCLE));
        else
            arg_mod = ANG_W'(arg_sum);
    end

    // stage 2: quarter-table index
    logic [IPROD_W-1:0] iprod;
    assign iprod = IPROD_W'(s2_ang_reg) * IPROD_W'(IDX_RECIP);

    // stage 3: quadrant fold
    logic [1:0]         quad;
    logic [SINE_AW-1:0] saddr;
    always_comb
    begin
        quad  = s3_idx_reg[I_BITS-1 -: 2];
        saddr = quad[0] ? SINE_AW'(SINE_TABLE_SIZE) - SINE_AW'(s3_idx_reg[S_BITS-1:0])
                        : SINE_AW'(s3_idx_reg[S_BITS-1:0]);
    end

    // stage 4: amplitude times sine, rounded half away from zero
    logic [AMP_W-1:0] amag;
    logic [32:0]      sprod;
    assign amag  = s4_amp_reg[AMP_W-1] ? AMP_W'(-s4_amp_reg) : AMP_W'(s4_amp_reg);
    assign sprod = 33'(amag) * 33'(sine_reg);

    // stage 6: quotient estimate, one low at most
    logic [AMP_W-1:0] qe;
    assign qe = s6_m1_reg[31 -: AMP_W];

    // stage 7: correction, offset and saturation
    logic [AMP_W-1:0]       q_fin;
    logic signed [17:0]     osc;
    logic signed [17:0]     sum_val;
    logic signed [AMP_W-1:0] sat_val;
    logic                   neg_off;

    always_comb
    begin
        if (!ramp_on_reg)
            q_fin = s7_mag_reg;
        else if (s7_t_reg <= {1'b0, s7_p_reg})
            q_fin = s7_qe_reg + AMP_W'(1);
        else
            q_fin = s7_qe_reg;
        osc     = s7_sign_reg ? -$signed(18'(q_fin)) : $signed(18'(q_fin));
        neg_off = s7_j_reg == NEG_OFF_LO || s7_j_reg == NEG_OFF_HI;
        sum_val = neg_off ? osc - 18'(s7_off_reg) : osc + 18'(s7_off_reg);
        if (sum_val > ANGLE_MAX)
            sat_val = ANGLE_MAX[AMP_W-1:0];
        else if (sum_val < ANGLE_MIN)
            sat_val = ANGLE_MIN[AMP_W-1:0];
        else
            sat_val = sum_val[AMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s6_v_reg      <= 1'b0;
            s7_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg      <= issue;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= s4_v_reg;
            s6_v_reg      <= s5_v_reg;
            s7_v_reg      <= s6_v_reg;
            out_valid_reg <= s7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_j_reg  <= joint_cnt_reg;
            s1_ok_reg <= src_ok && entry_valid_reg[raddr];

            s2_j_reg   <= s1_j_reg;
            s2_amp_reg <= e_amp;
            s2_off_reg <= e_off;
            s2_ang_reg <= arg_mod;

            s3_j_reg   <= s2_j_reg;
            s3_amp_reg <= s2_amp_reg;
            s3_off_reg <= s2_off_reg;
            s3_idx_reg <= iprod[IDX_SHIFT +: I_BITS];

            s4_j_reg   <= s3_j_reg;
            s4_amp_reg <= s3_amp_reg;
            s4_off_reg <= s3_off_reg;
            s4_neg_reg <= quad[1];
            sine_reg   <= SINE_Q[saddr];

            s5_j_reg    <= s4_j_reg;
            s5_off_reg  <= s4_off_reg;
            s5_mag_reg  <= AMP_W'((sprod + 33'(SINE_ROUND)) >> SINE_SHIFT);
            s5_sign_reg <= s4_amp_reg[AMP_W-1] ^ s4_neg_reg;

            s6_j_reg    <= s5_j_reg;
            s6_off_reg  <= s5_off_reg;
            s6_mag_reg  <= s5_mag_reg;
            s6_sign_reg <= s5_sign_reg;
            s6_m1_reg   <= 32'(s5_mag_reg) * 32'(frac_reg);
            s6_p_reg    <= 32'(s5_mag_reg) * 32'(pos_reg);

            s7_j_reg    <= s6_j_reg;
            s7_off_reg  <= s6_off_reg;
            s7_mag_reg  <= s6_mag_reg;
            s7_sign_reg <= s6_sign_reg;
            s7_qe_reg   <= qe;
            s7_p_reg    <= s6_p_reg;
            s7_t_reg    <= 33'(17'(qe) + 17'd1) * 33'(ramp_len_reg);

            joint_index_reg  <= s7_j_reg;
            angle_reg        <= sat_val;
            finished_out_reg <= fin_w_reg;
            last_reg         <= s7_j_reg == JOINT_LAST;
        end
    end

    assign result_valid = out_valid_reg;
    assign joint_index  = joint_index_reg;
    assign angle        = angle_reg;
    assign finished     = finished_out_reg;
    assign last         = last_reg;

endmodule

// File: hw/rtl/sjpg_check.sv
module sjpg_check
    import sjpg_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_stall,
    input logic                     cmd,
    input logic                     result_valid,
    input logic                     result_stall,
    input logic [JOINT_W-1:0]       joint_index,
    input logic signed [AMP_W-1:0]  angle,
    input logic                     finished,
    input logic                     last
);

    // a stalled beat stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(angle)
            && $stable(joint_index) && $stable(last))
        else $error("result beat changed under stall");

    // last marks the final joint only
    a_last_joint: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> joint_index == JOINT_LAST)
        else $error("last on a joint other than the final one");

    // finished never drops once shown
    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && finished |=> !result_valid || finished)
        else $error("finished mark dropped");

    // a tick holds off further items while it runs
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && cmd == CMD_TICK |=> item_stall)
        else $error("item taken right after a tick");

endmodule

bind sinusoidal_joint_pattern_generator sjpg_check u_sjpg_check (.*);
